### rtl/bounded_id_set_defines.svh
// Assertion helpers for the RTL datapath.
`ifndef BOUNDED_ID_SET_DEFINES_SVH
`define BOUNDED_ID_SET_DEFINES_SVH

// Checked only outside reset.
`define BIS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define BIS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/bis_pkg.sv
`default_nettype none

package bis_pkg;

  localparam int ID_W  = 32;
  localparam int CNT_W = 6;
  localparam int OP_W  = 2;

  localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
  localparam logic [OP_W-1:0] OP_DEL  = 2'd1;
  localparam logic [OP_W-1:0] OP_FIND = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic shift_start;
    logic shift_wr;
    logic append;
    logic remove;
    logic finish;
    logic res_err;
    logic res_present;
  } bis_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            is_null;
    logic            full;
    logic            empty;
    logic            hit;
    logic            exhausted;
    logic            res_free;
  } bis_stat_t;

endpackage

`default_nettype wire

### rtl/bis_dp.sv
`default_nettype none

`include "bounded_id_set_defines.svh"

module bis_dp #(
  parameter int CAPACITY = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_valid,
  input  wire logic [bis_pkg::ID_W-1:0]   cfg_data,
  input  wire logic [bis_pkg::OP_W-1:0]   req_type,
  input  wire logic [bis_pkg::ID_W-1:0]   ident,
  input  wire bis_pkg::bis_cmd_t          cmd,
  output bis_pkg::bis_stat_t              stat,
  output logic                            res_valid,
  input  wire logic                       res_ready,
  output logic                            status_code,
  output logic                            present,
  output logic [bis_pkg::CNT_W-1:0]       entry_count
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [bis_pkg::ID_W-1:0] mem [CAPACITY];

  logic [bis_pkg::ID_W-1:0] null_code;
  logic [bis_pkg::OP_W-1:0] op_q;
  logic [bis_pkg::ID_W-1:0] ident_q;
  logic [CW-1:0]            count;
  logic [CW-1:0]            idx;
  logic [bis_pkg::ID_W-1:0] rd_data;
  logic                     cmp_valid;
  logic [AW-1:0]            cmp_idx;
  logic                     issue;
  logic [AW-1:0]            wr_addr;

  assign issue   = idx < count;
  assign wr_addr = cmp_idx - AW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      null_code <= '1;
      count     <= '0;
      cmp_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        null_code <= cfg_data;
      end
      if (cmd.load || cmd.shift_start) begin
        cmp_valid <= 1'b0;
      end else begin
        cmp_valid <= cmd.scan && issue;
      end
      if (cmd.append) begin
        count <= count + CW'(1);
      end else if (cmd.remove) begin
        count <= count - CW'(1);
      end
      if (cmd.finish) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= req_type;
      ident_q <= ident;
      idx     <= '0;
    end else if (cmd.shift_start) begin
      idx <= CW'(cmp_idx) + CW'(1);
    end else if (cmd.scan && issue) begin
      idx     <= idx + CW'(1);
      cmp_idx <= idx[AW-1:0];
    end
    if (cmd.finish) begin
      status_code <= cmd.res_err;
      present     <= cmd.res_present;
      entry_count <= bis_pkg::CNT_W'(count);
    end
  end

  // single write port: append at the tail, or move an entry down one place
  always_ff @(posedge clk) begin
    if (cmd.scan && issue) begin
      rd_data <= mem[idx[AW-1:0]];
    end
    if (cmd.append) begin
      mem[count[AW-1:0]] <= ident_q;
    end else if (cmd.shift_wr && cmp_valid) begin
      mem[wr_addr] <= rd_data;
    end
  end

  always_comb begin
    stat.op        = op_q;
    stat.is_null   = ident_q == null_code;
    stat.full      = count == CW'(CAPACITY);
    stat.empty     = count == '0;
    stat.hit       = cmp_valid && (rd_data == ident_q);
    stat.exhausted = !cmp_valid && !issue;
    stat.res_free  = !res_valid || res_ready;
  end

  `BIS_ASSERT_ALWAYS(a_reset_clears, rst |=> (count == '0 && !res_valid), "reset left state behind")
  `BIS_ASSERT(a_count_bound, count <= CW'(CAPACITY), "count above capacity")
  `BIS_ASSERT(a_append_room, cmd.append |-> count < CW'(CAPACITY), "append into a full list")
  `BIS_ASSERT(a_remove_nonempty, cmd.remove |-> count != '0, "remove from an empty list")
  `BIS_ASSERT(a_finish_free, cmd.finish |-> (!res_valid || res_ready), "result overwritten")
  `BIS_ASSERT(a_shift_in_range, (cmd.shift_wr && cmp_valid) |-> (CW'(cmp_idx) < count && cmp_idx != '0), "shift outside list")

endmodule

`default_nettype wire

### rtl/bis_ctrl.sv
`default_nettype none

module bis_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_ready,
  input  wire bis_pkg::bis_stat_t  stat,
  output bis_pkg::bis_cmd_t        cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  state_t state;
  logic   res_err;
  logic   res_present;

  assign req_ready = state == S_IDLE;

  always_comb begin
    cmd             = '0;
    cmd.res_err     = res_err;
    cmd.res_present = res_present;
    case (state)
      S_IDLE: begin
        cmd.load = req_valid;
      end
      S_SCAN: begin
        if (stat.hit) begin
          cmd.shift_start = stat.op == bis_pkg::OP_DEL;
        end else begin
          cmd.scan   = 1'b1;
          cmd.append = stat.exhausted && (stat.op == bis_pkg::OP_ADD);
        end
      end
      S_SHIFT: begin
        cmd.scan     = 1'b1;
        cmd.shift_wr = 1'b1;
        cmd.remove   = stat.exhausted;
      end
      S_DONE: begin
        cmd.finish = stat.res_free;
      end
      default: begin
        cmd.load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      res_err     <= 1'b0;
      res_present <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          res_present <= 1'b0;
          res_err     <= 1'b0;
          case (stat.op)
            bis_pkg::OP_ADD: begin
              if (stat.is_null || stat.full) begin
                res_err <= 1'b1;
                state   <= S_DONE;
              end else begin
                state <= S_SCAN;
              end
            end
            bis_pkg::OP_DEL: begin
              if (stat.is_null || stat.empty) begin
                res_err <= 1'b1;
                state   <= S_DONE;
              end else begin
                state <= S_SCAN;
              end
            end
            bis_pkg::OP_FIND: begin
              state <= stat.is_null ? S_DONE : S_SCAN;
            end
            default: begin
              res_err <= 1'b1;
              state   <= S_DONE;
            end
          endcase
        end
        S_SCAN: begin
          if (stat.hit) begin
            case (stat.op)
              bis_pkg::OP_ADD: begin
                res_err <= 1'b1;
                state   <= S_DONE;
              end
              bis_pkg::OP_DEL: begin
                state <= S_SHIFT;
              end
              default: begin
                res_present <= 1'b1;
                state       <= S_DONE;
              end
            endcase
          end else if (stat.exhausted) begin
            // a delete that misses is an error; add appends, find reports absent
            res_err <= stat.op == bis_pkg::OP_DEL;
            state   <= S_DONE;
          end
        end
        S_SHIFT: begin
          if (stat.exhausted) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (stat.res_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/bounded_id_set.sv
// Packed, insertion-ordered set of up to CAPACITY distinct 32-bit ids with a
// running count. Each request adds, deletes or finds one id and returns one
// result carrying status, membership (find only) and the count afterwards.
// The list sits in a memory with one read and one write port, read one entry
// per cycle. A request settled at the check (null id, add to a full list,
// delete from an empty one, unused operation code) goes straight to its
// result. An add or find walks the held entries one a cycle and stops at a
// match. A delete walks to the match, then moves the later entries down one
// a cycle. A result not yet taken holds the block until the output register
// frees. Requests are handled one at a time; the next is taken as soon as
// the result is in the output register. The null id code register may be
// written at any time the block is idle and is always ready. No clearing
// pass follows reset: slots beyond the count are never read.
`default_nettype none

module bounded_id_set #(
  parameter int CAPACITY = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [bis_pkg::ID_W-1:0]  cfg_data,
  input  wire logic                      req_valid,
  output logic                           req_ready,
  input  wire logic [bis_pkg::OP_W-1:0]  req_type,
  input  wire logic [bis_pkg::ID_W-1:0]  ident,
  output logic                           res_valid,
  input  wire logic                      res_ready,
  output logic                           status_code,
  output logic                           present,
  output logic [bis_pkg::CNT_W-1:0]      entry_count
);

  bis_pkg::bis_cmd_t  cmd;
  bis_pkg::bis_stat_t stat;

  assign cfg_ready = 1'b1;

  bis_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bis_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .req_type    (req_type),
    .ident       (ident),
    .cmd         (cmd),
    .stat        (stat),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .status_code (status_code),
    .present     (present),
    .entry_count (entry_count)
  );

endmodule

`default_nettype wire

### sim/id_set_checker.sv
module id_set_checker #(
  parameter int CAPACITY = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [bis_pkg::ID_W-1:0] cfg_data,
  input  logic                     req_valid,
  input  logic                     req_ready,
  input  logic [bis_pkg::OP_W-1:0] req_type,
  input  logic [bis_pkg::ID_W-1:0] ident,
  input  logic                     res_valid,
  input  logic                     res_ready,
  input  logic                     status_code,
  input  logic                     present,
  input  logic [bis_pkg::CNT_W-1:0] entry_count,
  output int                       errors,
  output int                       awaited,
  output int                       checked,
  output int                       full_rejects
);

  localparam logic ST_OK  = 1'b0;
  localparam logic ST_ERR = 1'b1;

  typedef logic [bis_pkg::ID_W-1:0] word_t;

  typedef struct packed {
    logic                      status;
    logic                      present;
    logic [bis_pkg::CNT_W-1:0] count;
  } set_result_t;

  logic [bis_pkg::ID_W-1:0] id_list [CAPACITY];
  int                       held;
  logic [bis_pkg::ID_W-1:0] null_code;
  set_result_t              awaited_results [$];

  task automatic report(input string what, input logic [bis_pkg::ID_W-1:0] got,
                        input logic [bis_pkg::ID_W-1:0] want);
    // keep the log short if the block is badly broken
    if (errors < 40)
      $display("mismatch on result %0d: %s got %0h, expected %0h", checked, what, got, want);
    errors++;
  endtask

  // position of id in the held part of the list, -1 if absent; null never matches
  function automatic int find_slot(input logic [bis_pkg::ID_W-1:0] id);
    if (id == null_code) return -1;
    for (int i = 0; i < held; i++)
      if (id_list[i] == id) return i;
    return -1;
  endfunction

  function automatic set_result_t apply_request(input logic [bis_pkg::OP_W-1:0] op,
                                                input logic [bis_pkg::ID_W-1:0] id);
    set_result_t r;
    int          slot;
    r.status  = ST_ERR;
    r.present = 1'b0;
    slot = find_slot(id);
    case (op)
      bis_pkg::OP_ADD: begin
        if (id != null_code && held < CAPACITY && slot < 0) begin
          id_list[held] = id;
          held++;
          r.status = ST_OK;
        end else if (id != null_code && held == CAPACITY) begin
          full_rejects++;
        end
      end
      bis_pkg::OP_DEL: begin
        if (slot >= 0) begin
          for (int i = slot; i + 1 < held; i++) id_list[i] = id_list[i+1];
          id_list[held-1] = null_code;
          held--;
          r.status = ST_OK;
        end
      end
      bis_pkg::OP_FIND: begin
        r.present = (slot >= 0);
        r.status  = ST_OK;
      end
      default: ;
    endcase
    r.count = held[bis_pkg::CNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin : track
    set_result_t want;
    if (rst) begin
      null_code = '1;
      for (int i = 0; i < CAPACITY; i++) id_list[i] = '1;
      held = 0;
      errors = 0;
      checked = 0;
      full_rejects = 0;
      awaited_results.delete();
      awaited <= 0;
    end else begin
      // a result leaving at this edge belongs to an earlier request
      if (res_valid && res_ready) begin
        if (awaited_results.size() == 0) begin
          report("result with no request outstanding", word_t'(entry_count), '0);
        end else begin
          want = awaited_results.pop_front();
          if (status_code !== want.status)
            report("status_code", word_t'(status_code), word_t'(want.status));
          if (present !== want.present)
            report("present", word_t'(present), word_t'(want.present));
          if (entry_count !== want.count)
            report("entry_count", word_t'(entry_count), word_t'(want.count));
        end
        checked++;
      end
      if (cfg_valid && cfg_ready) null_code = cfg_data;
      if (req_valid && req_ready) awaited_results.push_back(apply_request(req_type, ident));
      awaited <= awaited_results.size();
    end
  end

endmodule

### sim/testbench.sv
module testbench;

  localparam int                       CAPACITY    = 32;
  localparam logic [bis_pkg::OP_W-1:0] OP_UNUSED   = 2'd3;
  localparam int                       RANDOM_REQS = 1530;
  localparam int                       POOL_SIZE   = 48;
  localparam int                       CYCLE_LIMIT = 1_000_000;
  localparam logic [bis_pkg::ID_W-1:0] ID_LOW      = 32'h0000_0000;
  localparam logic [bis_pkg::ID_W-1:0] ID_HIGH     = 32'hFFFF_FFFE;
  localparam logic [bis_pkg::ID_W-1:0] ID_MID      = 32'h1234_5678;
  localparam logic [bis_pkg::ID_W-1:0] ID_ALL_ONES = 32'hFFFF_FFFF;

  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN} mix_t;
  typedef enum int {RX_OPEN, RX_COIN, RX_SLOW} rx_mode_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_valid = 1'b0;
  logic [bis_pkg::ID_W-1:0]  cfg_data = '0;
  logic                      req_valid = 1'b0;
  logic [bis_pkg::OP_W-1:0]  req_type = bis_pkg::OP_ADD;
  logic [bis_pkg::ID_W-1:0]  ident = '0;
  logic                      res_ready = 1'b0;
  logic                      cfg_ready;
  logic                      req_ready;
  logic                      res_valid;
  logic                      status_code;
  logic                      present;
  logic [bis_pkg::CNT_W-1:0] entry_count;

  int errors, awaited, checked, full_rejects;
  int cycles = 0;
  int burst_left = 0;
  int sent = 0;
  int null_writes = 0;
  int phase_no = 0;
  int phase_len;
  mix_t mix;
  logic [bis_pkg::ID_W-1:0] id_pool [POOL_SIZE];
  logic [bis_pkg::ID_W-1:0] null_now = ID_ALL_ONES;

  rx_mode_t rx_mode = RX_OPEN;
  int       rx_mode_left = 0;
  int       rx_hold = 0;

  always #1 clk = ~clk;

  bounded_id_set #(.CAPACITY(CAPACITY)) u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req_type   (req_type),
    .ident      (ident),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .status_code(status_code),
    .present    (present),
    .entry_count(entry_count)
  );

  id_set_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req_type    (req_type),
    .ident       (ident),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .status_code (status_code),
    .present     (present),
    .entry_count (entry_count),
    .errors      (errors),
    .awaited     (awaited),
    .checked     (checked),
    .full_rejects(full_rejects)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timed out after %0d cycles, %0d results outstanding", cycles, awaited);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: open, coin-toss, or long stalls broken by a single ready cycle
  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      rx_mode_left = $urandom_range(50, 400);
    end
    rx_mode_left--;
    case (rx_mode)
      RX_OPEN: res_ready <= 1'b1;
      RX_COIN: res_ready <= ($urandom_range(0, 1) == 1);
      default: begin
        if (rx_hold == 0) rx_hold = $urandom_range(1, 40);
        rx_hold--;
        res_ready <= (rx_hold == 0);
      end
    endcase
  end

  task automatic send_request(input logic [bis_pkg::OP_W-1:0] op,
                              input logic [bis_pkg::ID_W-1:0] id);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        if (req_valid) req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_valid <= 1'b1;
    req_type  <= op;
    ident     <= id;
    do @(posedge clk); while (!req_ready);
    sent++;
  endtask

  // hold off until every outstanding request has its result
  task automatic drain();
    if (req_valid) req_valid <= 1'b0;
    do @(posedge clk); while (awaited != 0);
    burst_left = 0;
  endtask

  task automatic write_null(input logic [bis_pkg::ID_W-1:0] code);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= code;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    null_now = code;
    null_writes++;
  endtask

  function automatic logic [bis_pkg::OP_W-1:0] pick_op(input mix_t m);
    int r;
    int add_pct;
    int del_pct;
    r = $urandom_range(0, 99);
    case (m)
      MIX_GROW:   begin add_pct = 70; del_pct = 10; end
      MIX_SHRINK: begin add_pct = 15; del_pct = 60; end
      default:    begin add_pct = 35; del_pct = 35; end
    endcase
    if (r < 3) return OP_UNUSED;
    if (r < 3 + add_pct) return bis_pkg::OP_ADD;
    if (r < 3 + add_pct + del_pct) return bis_pkg::OP_DEL;
    return bis_pkg::OP_FIND;
  endfunction

  function automatic logic [bis_pkg::ID_W-1:0] pick_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return id_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (r < 88) return null_now;
    if (r < 92) return ($urandom_range(0, 1) == 1) ? ID_ALL_ONES : ID_LOW;
    return $urandom;
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: empty list, null code, duplicates, unused op, shift on delete
    send_request(bis_pkg::OP_FIND, ID_LOW);
    send_request(bis_pkg::OP_DEL, ID_MID);
    send_request(bis_pkg::OP_ADD, ID_ALL_ONES);
    send_request(bis_pkg::OP_ADD, ID_LOW);
    send_request(bis_pkg::OP_ADD, ID_HIGH);
    send_request(bis_pkg::OP_ADD, ID_LOW);
    send_request(bis_pkg::OP_ADD, ID_MID);
    send_request(bis_pkg::OP_FIND, ID_LOW);
    send_request(bis_pkg::OP_FIND, ID_ALL_ONES);
    send_request(OP_UNUSED, ID_LOW);
    send_request(bis_pkg::OP_DEL, 32'h0000_0077);
    send_request(bis_pkg::OP_DEL, ID_LOW);
    send_request(bis_pkg::OP_FIND, ID_HIGH);
    send_request(bis_pkg::OP_DEL, ID_ALL_ONES);
    send_request(bis_pkg::OP_FIND, ID_LOW);
    // null code moved onto a held id: it stays but can't be found or removed
    write_null(ID_MID);
    send_request(bis_pkg::OP_FIND, ID_MID);
    send_request(bis_pkg::OP_DEL, ID_MID);
    send_request(bis_pkg::OP_ADD, ID_MID);
    send_request(bis_pkg::OP_ADD, ID_ALL_ONES);
    send_request(bis_pkg::OP_FIND, ID_ALL_ONES);
    write_null(ID_LOW);
    send_request(bis_pkg::OP_ADD, ID_LOW);
    send_request(bis_pkg::OP_DEL, ID_HIGH);
    send_request(bis_pkg::OP_DEL, ID_ALL_ONES);

    while (sent < RANDOM_REQS + 23) begin
      if (phase_no % 3 == 0)
        foreach (id_pool[i]) id_pool[i] = $urandom;
      case (phase_no)
        0:       write_null(ID_ALL_ONES);
        1:       write_null(ID_LOW);
        2:       write_null(id_pool[$urandom_range(0, POOL_SIZE - 1)]);
        default: begin
          case ($urandom_range(0, 3))
            0:       write_null(ID_ALL_ONES);
            1:       write_null(ID_LOW);
            2:       write_null(id_pool[$urandom_range(0, POOL_SIZE - 1)]);
            default: write_null($urandom);
          endcase
        end
      endcase
      mix = mix_t'(phase_no % 3);
      phase_len = $urandom_range(80, 220);
      for (int n = 0; n < phase_len && sent < RANDOM_REQS + 23; n++) begin
        if ($urandom_range(0, 99) == 0) drain();
        send_request(pick_op(mix), pick_id());
      end
      phase_no++;
    end

    drain();
    repeat (50) @(posedge clk);
    $display("%0d requests sent across %0d null code settings, %0d results checked",
             sent, null_writes, checked);
    $display("adds refused on a full list: %0d", full_rejects);
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
